### src/keyed_priority_queue_core_assert.svh
// Assertion macros for the keyed priority queue core.
`ifndef KEYED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define KEYED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define KPQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpq assertion failed");
// Check that cons holds in the cycle after ante.
`define KPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpq assertion failed");
`else
`define KPQ_ASSERT_SAME(label, ante, cons)
`define KPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/kpq_pkg.sv
// Shared codes and types of the keyed priority queue.
`timescale 1ns / 1ps
package kpq_pkg;

  // Request types
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;
  localparam logic [1:0] REQ_POP    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int OCC_W = 5;

  // Cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DROP   = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  // Flags a cell hands to its right neighbor
  typedef struct packed {
    logic ge;    // entry in use with priority >= request priority
    logic past;  // a key match sits at or before this cell
  } cell_flags_t;

endpackage

### src/kpq_req_if.sv
// Request channel interface of the keyed priority queue.
`timescale 1ns / 1ps
interface kpq_req_if #(
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [KEY_BITS-1:0]  req_key;
  logic [PRIO_BITS-1:0] req_priority;

  modport source(output valid, req_type, req_key, req_priority, input ready);
  modport sink(input valid, req_type, req_key, req_priority, output ready);
endinterface

### src/kpq_rsp_if.sv
// Result channel interface of the keyed priority queue.
`timescale 1ns / 1ps
interface kpq_rsp_if #(
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [KEY_BITS-1:0]  out_key;
  logic [PRIO_BITS-1:0] out_priority;
  logic [4:0]           occupancy;

  modport source(output valid, status, out_key, out_priority, occupancy, input ready);
  modport sink(input valid, status, out_key, out_priority, occupancy, output ready);
endinterface

### src/kpq_cell.sv
// One slot of the sorted list: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps
module kpq_cell
  import kpq_pkg::*;
#(
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  logic [1:0]           op,
  input  logic                 in_use,
  input  logic [KEY_BITS-1:0]  req_key,
  input  logic [PRIO_BITS-1:0] req_priority,
  input  cell_flags_t          left_flags,
  input  logic [KEY_BITS-1:0]  left_key,
  input  logic [PRIO_BITS-1:0] left_priority,
  input  logic [PRIO_BITS-1:0] left_cap,
  input  logic [KEY_BITS-1:0]  right_key,
  input  logic [PRIO_BITS-1:0] right_priority,
  output cell_flags_t          flags,
  output logic [KEY_BITS-1:0]  key,
  output logic [PRIO_BITS-1:0] priority_q,
  output logic [PRIO_BITS-1:0] cap
);

  logic                 past;
  logic                 match;
  logic [KEY_BITS-1:0]  key_next;
  logic [PRIO_BITS-1:0] prio_next;

  assign match     = in_use && (key == req_key);
  assign flags.ge  = in_use && (priority_q >= req_priority);
  assign flags.past = past;

  // Search wave: the first match and its priority ripple rightward one cell a cycle.
  always_ff @(posedge clk) begin
    past <= left_flags.past | match;
    cap  <= left_flags.past ? left_cap : priority_q;
  end

  always_comb begin
    key_next  = key;
    prio_next = priority_q;
    case (op)
      OP_INSERT: begin
        if (!flags.ge) begin
          if (left_flags.ge) begin
            key_next  = req_key;
            prio_next = req_priority;
          end else begin
            key_next  = left_key;
            prio_next = left_priority;
          end
        end
      end
      OP_DROP: begin
        if (past) begin
          key_next  = right_key;
          prio_next = right_priority;
        end
      end
      OP_POP: begin
        key_next  = right_key;
        prio_next = right_priority;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    priority_q <= prio_next;
  end

endmodule

### src/keyed_priority_queue_core.sv
// Top level of the keyed priority queue: cell chain, request sequencer, result register.
`timescale 1ns / 1ps
// Keyed priority queue. Holds up to DEPTH (key, priority) entries in a row of
// cells, sorted from highest to lowest priority, equal priorities in arrival
// order. Each request word on req gives exactly one result word on rsp.
// Insert and pop latch the request, then every cell shifts or loads in
// parallel as the result is written. Remove and update first run the key
// search, a wave that moves one cell per cycle down the chain, so its
// length is set by DEPTH; then comes the drop, and for update the reinsert.
// One request is in flight at a time; a finished result waits in the
// output register while the next request is accepted, and the sequencer
// stalls only when it must write a new result while the old one has not
// yet been taken. Duplicate keys are allowed; remove and update act on the
// one nearest the head.
module keyed_priority_queue_core
  import kpq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int KEY_BITS  = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  kpq_req_if.sink   req,
  kpq_rsp_if.source rsp
);

`include "keyed_priority_queue_core_assert.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;

  logic [2:0]           state, state_next;
  logic [IDX_W-1:0]     step, step_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [1:0]           cur_type;
  logic [KEY_BITS-1:0]  cur_key;
  logic [PRIO_BITS-1:0] cur_prio;
  logic [PRIO_BITS-1:0] old_prio, old_prio_next;
  logic [1:0]           cell_op;
  logic                 out_free;
  logic                 found;

  // result register
  logic                 rsp_valid;
  logic [1:0]           rsp_status;
  logic [KEY_BITS-1:0]  rsp_key;
  logic [PRIO_BITS-1:0] rsp_prio;
  logic [OCC_W-1:0]     rsp_occ;
  logic                 load;
  logic [1:0]           status_next;
  logic [KEY_BITS-1:0]  key_next;
  logic [PRIO_BITS-1:0] prio_next;
  logic [CNT_W-1:0]     occ_next;

  // cell chain wiring
  cell_flags_t          c_flags [DEPTH];
  logic [KEY_BITS-1:0]  c_key   [DEPTH];
  logic [PRIO_BITS-1:0] c_prio  [DEPTH];
  logic [PRIO_BITS-1:0] c_cap   [DEPTH];

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp.ready;
  // The tail of the search wave says whether any slot matched, and carries
  // the priority of the first match.
  assign found     = c_flags[DEPTH-1].past;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_flags_t          l_flags;
      logic [KEY_BITS-1:0]  l_key;
      logic [PRIO_BITS-1:0] l_prio;
      logic [PRIO_BITS-1:0] l_cap;
      logic [KEY_BITS-1:0]  r_key;
      logic [PRIO_BITS-1:0] r_prio;

      if (i == 0) begin : g_head
        // Head cell: everything ahead of it counts as higher priority, no match.
        assign l_flags = '{ge: 1'b1, past: 1'b0};
        assign l_key   = '0;
        assign l_prio  = '0;
        assign l_cap   = '0;
      end else begin : g_body
        assign l_flags = c_flags[i-1];
        assign l_key   = c_key[i-1];
        assign l_prio  = c_prio[i-1];
        assign l_cap   = c_cap[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_key  = '0;
        assign r_prio = '0;
      end else begin : g_inner
        assign r_key  = c_key[i+1];
        assign r_prio = c_prio[i+1];
      end

      kpq_cell #(
        .KEY_BITS (KEY_BITS),
        .PRIO_BITS(PRIO_BITS)
      ) u_cell (
        .clk           (clk),
        .op            (cell_op),
        .in_use        (count > CNT_W'(i)),
        .req_key       (cur_key),
        .req_priority  (cur_prio),
        .left_flags    (l_flags),
        .left_key      (l_key),
        .left_priority (l_prio),
        .left_cap      (l_cap),
        .right_key     (r_key),
        .right_priority(r_prio),
        .flags         (c_flags[i]),
        .key           (c_key[i]),
        .priority_q    (c_prio[i]),
        .cap           (c_cap[i])
      );
    end
  endgenerate

  // Sequencer: pick the cell operation and the result for each step.
  always_comb begin
    state_next    = state;
    step_next     = step;
    count_next    = count;
    old_prio_next = old_prio;
    cell_op       = OP_HOLD;
    load          = 1'b0;
    status_next   = ST_OK;
    key_next      = '0;
    prio_next     = '0;
    occ_next      = count;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur_type == REQ_INSERT) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = S_IDLE;
            if (count == CNT_W'(DEPTH)) begin
              status_next = ST_FULL;
            end else begin
              cell_op    = OP_INSERT;
              count_next = count + 1'b1;
              occ_next   = count + 1'b1;
            end
          end
        end else if (cur_type == REQ_POP) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = S_IDLE;
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else begin
              cell_op    = OP_POP;
              key_next   = c_key[0];
              prio_next  = c_prio[0];
              count_next = count - 1'b1;
              occ_next   = count - 1'b1;
            end
          end
        end else begin
          step_next  = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // let the match wave settle across the whole chain
        if (step == IDX_W'(DEPTH - 1)) begin
          state_next = S_DEL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DEL: begin
        if (!found) begin
          if (out_free) begin
            load        = 1'b1;
            status_next = ST_NOT_FOUND;
            state_next  = S_IDLE;
          end
        end else if (cur_type == REQ_REMOVE) begin
          if (out_free) begin
            load       = 1'b1;
            cell_op    = OP_DROP;
            key_next   = cur_key;
            prio_next  = c_cap[DEPTH-1];
            count_next = count - 1'b1;
            occ_next   = count - 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          // update: drop now, reinsert behind its new equals in S_INS
          cell_op       = OP_DROP;
          count_next    = count - 1'b1;
          old_prio_next = c_cap[DEPTH-1];
          state_next    = S_INS;
        end
      end
      S_INS: begin
        if (out_free) begin
          load       = 1'b1;
          cell_op    = OP_INSERT;
          key_next   = cur_key;
          prio_next  = old_prio;
          count_next = count + 1'b1;
          occ_next   = count + 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    step     <= step_next;
    old_prio <= old_prio_next;
    if (req.valid && req.ready) begin
      cur_type <= req.req_type;
      cur_key  <= req.req_key;
      cur_prio <= req.req_priority;
    end
    if (load) begin
      rsp_status <= status_next;
      rsp_key    <= key_next;
      rsp_prio   <= prio_next;
      rsp_occ    <= OCC_W'(occ_next);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.out_key      = rsp_key;
  assign rsp.out_priority = rsp_prio;
  assign rsp.occupancy    = rsp_occ;

  // Occupancy never exceeds the number of cells.
  `KPQ_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  // A refused insert only happens on a full queue, an empty pop only on an empty one.
  `KPQ_ASSERT_SAME(a_full_occ, load && status_next == ST_FULL, count == CNT_W'(DEPTH))
  `KPQ_ASSERT_SAME(a_empty_occ, load && status_next == ST_EMPTY, count == '0)
  // A drop removes exactly one entry.
  `KPQ_ASSERT_NEXT(a_drop_count, cell_op == OP_DROP, count == $past(count) - 1'b1)

endmodule
